@@ hw/rtl/csp_pkg.sv @@
// Shared types and constants of the cruise speed PID controller.
// Holds field widths, event and mode codes, register indexes and reset values.
// Used by every module of the block; depends on nothing else.
package csp_pkg;

    // Field widths fixed by the interface.
    localparam int KIND_W      = 3;
    localparam int VALUE_W     = 11;
    localparam int SPEED_OUT_W = 11;
    localparam int CMD_W       = 10;
    localparam int POS_W       = 8;
    localparam int MODE_OUT_W  = 3;
    localparam int GAIN_W      = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int INT_W       = 16;
    localparam int SECONDS_W   = 8;

    // Largest servo command.
    localparam int CMD_MAX = 1023;

    // Defaults of the top-level parameters.
    localparam int DEF_SPEED_BITS    = 11;
    localparam int DEF_SERVO_MAX_POS = 179;
    localparam int DEF_SERVO_MIN_POS = 1;

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN   = 8'd10;
    localparam logic [GAIN_W-1:0] RST_INT_GAIN    = 8'd5;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN  = 8'd2;
    localparam logic [GAIN_W-1:0] RST_SLOW_PERIOD = 8'd30;
    localparam logic [GAIN_W-1:0] RST_FAST_PERIOD = 8'd5;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_INITIAL  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_INITIAL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INT_GAIN     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DERIV_GAIN   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_PERIOD  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAST_PERIOD  = 3'd6;

    // Event codes on the input channel.
    localparam logic [KIND_W-1:0] KIND_THROTTLE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SPEED       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TICK        = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT_MODE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SETUP_ENTER = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SETUP_LEAVE = 3'd5;

    // Reported mode code while in setup.
    localparam logic [MODE_OUT_W-1:0] MODE_CODE_SETUP = 3'd4;

    // Classified operation handed from front to back.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_THROTTLE,
        OP_SPEED,
        OP_TICK,
        OP_NEXT_MODE,
        OP_SETUP_ENTER,
        OP_SETUP_LEAVE
    } t_op;

    // Operating mode.
    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_STATIC,
        MODE_SLOW,
        MODE_FAST
    } t_mode;

    // Queue entry: operation and its operand (throttle already clamped).
    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    // Result fields, servo position excepted.
    typedef struct packed {
        logic [CMD_W-1:0]       servo_command;
        logic [MODE_OUT_W-1:0]  mode;
        logic [SPEED_OUT_W-1:0] target_speed;
        logic [SPEED_OUT_W-1:0] low_speed;
        logic [SPEED_OUT_W-1:0] high_speed;
        logic                   autopilot;
        logic                   store_write;
    } t_result;

endpackage

@@ hw/rtl/csp_front.sv @@
// Front part: accepts input transactions, classifies the event and queues it.
// Depends on csp_pkg for event codes, the queue depth and the entry type.
module csp_front
    import csp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [VALUE_W-1:0] i_value,
    output t_cmd               o_head,
    output logic               o_head_valid,
    input  logic               i_pop
);

    localparam int IdxW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_entry [QUEUE_DEPTH];
    logic [IdxW-1:0] r_wr_ptr;
    logic [IdxW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    t_cmd            w_cmd;
    logic            w_push;

    // Classify the event; a throttle level above full scale is clamped here.
    always_comb begin
        w_cmd.value = i_value;
        case (i_kind)
            KIND_THROTTLE: begin
                w_cmd.op = OP_THROTTLE;
                if (i_value > VALUE_W'(CMD_MAX)) begin
                    w_cmd.value = VALUE_W'(CMD_MAX);
                end
            end
            KIND_SPEED:       w_cmd.op = OP_SPEED;
            KIND_TICK:        w_cmd.op = OP_TICK;
            KIND_NEXT_MODE:   w_cmd.op = OP_NEXT_MODE;
            KIND_SETUP_ENTER: w_cmd.op = OP_SETUP_ENTER;
            KIND_SETUP_LEAVE: w_cmd.op = OP_SETUP_LEAVE;
            default:          w_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_ready   = (r_count != CntW'(QUEUE_DEPTH));
    assign w_push       = i_in_valid && o_in_ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_entry[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + IdxW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + IdxW'(1);
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (!w_push && i_pop) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QUEUE_DEPTH))
        else $error("queue fill count exceeds its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");
`endif

endmodule

@@ hw/rtl/csp_exec.sv @@
// Back part: holds the controller state and configuration, applies one queued
// event per cycle while the output stage accepts results (PID update included)
// and registers the result fields. Depends on csp_pkg for codes and types.
module csp_exec
    import csp_pkg::*;
#(
    parameter int SPEED_BITS = DEF_SPEED_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    input  logic                  i_cmd_valid,
    output logic                  o_pop,
    output t_result               o_res,
    output logic                  o_res_valid,
    input  logic                  i_res_ready
);

    localparam int ErrW = SPEED_BITS + 1;
    localparam int DifW = SPEED_BITS + 2;
    localparam int AccW = ((ErrW > INT_W) ? ErrW : INT_W) + 1;
    localparam int PidW = ((SPEED_BITS + 11 > 25) ? SPEED_BITS + 11 : 25) + 3;
    localparam logic signed [AccW-1:0] IntHi = AccW'(32767);
    localparam logic signed [AccW-1:0] IntLo = AccW'(-32768);
    localparam logic signed [PidW-1:0] CmdHi = PidW'(CMD_MAX);

    // Configuration registers.
    logic [GAIN_W-1:0] r_prop_gain, r_int_gain, r_deriv_gain;
    logic [GAIN_W-1:0] r_slow_period, r_fast_period;

    // Controller state.
    t_mode                   r_mode, n_mode;
    logic                    r_setup, n_setup;
    logic [SPEED_BITS-1:0]   r_low, n_low;
    logic [SPEED_BITS-1:0]   r_high, n_high;
    logic [SPEED_BITS-1:0]   r_target, n_target;
    logic [SPEED_BITS-1:0]   r_speed, n_speed;
    logic [CMD_W-1:0]        r_servo, n_servo;
    logic signed [INT_W-1:0] r_integral, n_integral;
    logic signed [ErrW-1:0]  r_prev_err, n_prev_err;
    logic                    r_first, n_first;
    logic [SECONDS_W-1:0]    r_seconds, n_seconds;
    t_result                 r_res, n_res;
    logic                    r_res_valid;

    // PID datapath.
    logic [SPEED_BITS-1:0]   w_speed_in;
    logic                    w_autopilot;
    logic signed [ErrW-1:0]  w_err;
    logic signed [ErrW-1:0]  w_prev;
    logic signed [AccW-1:0]  w_acc;
    logic signed [INT_W-1:0] w_int_sat;
    logic signed [DifW-1:0]  w_dif;
    logic signed [PidW-1:0]  w_pid;
    logic signed [PidW-1:0]  w_cmd;
    logic [CMD_W-1:0]        w_cmd_clamped;
    logic [SECONDS_W:0]      w_sec_inc;

    assign o_pop       = i_cmd_valid && (!r_res_valid || i_res_ready);
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    assign w_speed_in  = SPEED_BITS'(i_cmd.value);
    assign w_autopilot = !r_setup && (r_mode != MODE_OFF) && (r_target != '0);

    // PID correction from a new speed sample; integral saturates at 16 bits.
    always_comb begin
        w_err  = $signed({1'b0, r_target}) - $signed({1'b0, w_speed_in});
        w_prev = r_first ? w_err : r_prev_err;
        w_acc  = AccW'(r_integral) + AccW'(w_err);
        if (w_acc > IntHi) begin
            w_int_sat = INT_W'(IntHi);
        end else if (w_acc < IntLo) begin
            w_int_sat = INT_W'(IntLo);
        end else begin
            w_int_sat = INT_W'(w_acc);
        end
        w_dif = DifW'(w_err) - DifW'(w_prev);
        w_pid = PidW'(w_err) * PidW'($signed({1'b0, r_prop_gain}))
              + PidW'(w_int_sat) * PidW'($signed({1'b0, r_int_gain}))
              + PidW'(w_dif) * PidW'($signed({1'b0, r_deriv_gain}));
        w_cmd = w_pid + PidW'($signed({1'b0, r_servo}));
        if (w_cmd < 0) begin
            w_cmd_clamped = '0;
        end else if (w_cmd > CmdHi) begin
            w_cmd_clamped = CMD_W'(CMD_MAX);
        end else begin
            w_cmd_clamped = CMD_W'(w_cmd);
        end
    end

    assign w_sec_inc = {1'b0, r_seconds} + (SECONDS_W + 1)'(1);

    // Next state and result of the event at the head of the queue.
    always_comb begin
        n_mode         = r_mode;
        n_setup        = r_setup;
        n_low          = r_low;
        n_high         = r_high;
        n_target       = r_target;
        n_speed        = r_speed;
        n_servo        = r_servo;
        n_integral     = r_integral;
        n_prev_err     = r_prev_err;
        n_first        = r_first;
        n_seconds      = r_seconds;
        n_res          = r_res;
        n_res.store_write = 1'b0;

        if (o_pop) begin
            case (i_cmd.op)
                OP_THROTTLE: begin
                    n_mode  = MODE_OFF;
                    n_servo = CMD_W'(i_cmd.value);
                end
                OP_SPEED: begin
                    n_speed = w_speed_in;
                    if (w_autopilot) begin
                        n_servo    = w_cmd_clamped;
                        n_integral = w_int_sat;
                        n_prev_err = w_err;
                        n_first    = 1'b0;
                    end
                end
                OP_TICK: begin
                    if (!w_autopilot || r_mode == MODE_STATIC) begin
                        n_seconds = '0;
                    end else if ((r_mode == MODE_SLOW && w_sec_inc > {1'b0, r_slow_period})
                              || (r_mode == MODE_FAST && w_sec_inc > {1'b0, r_fast_period}))
                    begin
                        n_target  = (r_target == r_low) ? r_high : r_low;
                        n_seconds = '0;
                    end else if (w_sec_inc[SECONDS_W]) begin
                        n_seconds = '1;
                    end else begin
                        n_seconds = w_sec_inc[SECONDS_W-1:0];
                    end
                end
                OP_NEXT_MODE: begin
                    case (r_mode)
                        MODE_OFF: begin
                            n_mode   = MODE_STATIC;
                            n_target = r_low;
                        end
                        MODE_STATIC: n_mode = MODE_SLOW;
                        MODE_SLOW:   n_mode = MODE_FAST;
                        default:     n_mode = MODE_STATIC;
                    endcase
                end
                OP_SETUP_ENTER: begin
                    n_setup = 1'b1;
                    n_low   = r_speed;
                end
                OP_SETUP_LEAVE: begin
                    n_setup = 1'b0;
                    if (r_speed < r_low) begin
                        n_high = r_low;
                        n_low  = r_speed;
                    end else begin
                        n_high = r_speed;
                    end
                    n_res.store_write = 1'b1;
                end
                default: begin
                end
            endcase

            n_res.servo_command = n_servo;
            n_res.mode          = n_setup ? MODE_CODE_SETUP : {1'b0, n_mode};
            n_res.target_speed  = SPEED_OUT_W'(n_target);
            n_res.low_speed     = SPEED_OUT_W'(n_low);
            n_res.high_speed    = SPEED_OUT_W'(n_high);
            n_res.autopilot     = !n_setup && (n_mode != MODE_OFF) && (n_target != '0);
        end

        // Speed set-points loaded from the configuration port; writing only while idle is up to the user.
        if (i_cfg_we && i_cfg_addr == CFG_LOW_INITIAL) begin
            n_low = SPEED_BITS'(i_cfg_data);
        end
        if (i_cfg_we && i_cfg_addr == CFG_HIGH_INITIAL) begin
            n_high = SPEED_BITS'(i_cfg_data);
        end
    end

    // Gain and period registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= RST_PROP_GAIN;
            r_int_gain    <= RST_INT_GAIN;
            r_deriv_gain  <= RST_DERIV_GAIN;
            r_slow_period <= RST_SLOW_PERIOD;
            r_fast_period <= RST_FAST_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_INT_GAIN:    r_int_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_SLOW_PERIOD: r_slow_period <= i_cfg_data[GAIN_W-1:0];
                CFG_FAST_PERIOD: r_fast_period <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF;
            r_setup    <= 1'b0;
            r_low      <= '0;
            r_high     <= '0;
            r_target   <= '0;
            r_speed    <= '0;
            r_servo    <= '0;
            r_integral <= '0;
            r_prev_err <= '0;
            r_first    <= 1'b1;
            r_seconds  <= '0;
        end else begin
            r_mode     <= n_mode;
            r_setup    <= n_setup;
            r_low      <= n_low;
            r_high     <= n_high;
            r_target   <= n_target;
            r_speed    <= n_speed;
            r_servo    <= n_servo;
            r_integral <= n_integral;
            r_prev_err <= n_prev_err;
            r_first    <= n_first;
            r_seconds  <= n_seconds;
        end
    end

    // Result register towards the output stage.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_pop) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_throttle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_cmd.op == OP_THROTTLE |=> r_mode == MODE_OFF && !r_res.autopilot)
        else $error("throttle event did not force off mode");

    a_leave_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_cmd.op == OP_SETUP_LEAVE |=> r_res.store_write && !r_setup)
        else $error("leaving setup did not request a store");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_res_ready |=> r_res_valid && $stable(r_res))
        else $error("result lost while the output stage was stalled");
`endif

endmodule

@@ hw/rtl/csp_out.sv @@
// Output stage: maps the servo command onto a servo position and holds the
// finished result for the output channel. Depends on csp_pkg for types.
module csp_out
    import csp_pkg::*;
#(
    parameter int SERVO_MAX_POS = DEF_SERVO_MAX_POS,
    parameter int SERVO_MIN_POS = DEF_SERVO_MIN_POS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_result                i_res,
    input  logic                   i_res_valid,
    output logic                   o_res_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [POS_W-1:0]       o_servo_position,
    output logic [CMD_W-1:0]       o_servo_command,
    output logic [MODE_OUT_W-1:0]  o_mode,
    output logic [SPEED_OUT_W-1:0] o_target_speed,
    output logic [SPEED_OUT_W-1:0] o_low_speed,
    output logic [SPEED_OUT_W-1:0] o_high_speed,
    output logic                   o_autopilot,
    output logic                   o_store_write
);

    localparam int Span    = SERVO_MAX_POS - SERVO_MIN_POS;
    localparam bit SpanNeg = (Span < 0);
    localparam int SpanAbs = SpanNeg ? -Span : Span;
    localparam int MagW    = CMD_W + POS_W;

    logic [MagW-1:0]  w_mag;
    logic [POS_W-1:0] w_q0;
    logic [MagW:0]    w_rem;
    logic [POS_W-1:0] w_q;
    logic [POS_W-1:0] w_offset;
    logic [POS_W-1:0] w_pos;
    logic             w_load;
    logic             r_valid;
    t_result          r_res;
    logic [POS_W-1:0] r_pos;

    // Position = MIN + cmd * (MAX - MIN) / 1023. The quotient by 1023 starts
    // from a shift by ten bits, which is at most one short; one compare fixes it.
    always_comb begin
        w_mag = MagW'(i_res.servo_command) * MagW'(SpanAbs);
        w_q0  = w_mag[MagW-1:CMD_W];
        w_rem = (MagW + 1)'(w_mag) - (MagW + 1)'({w_q0, {CMD_W{1'b0}}})
              + (MagW + 1)'(w_q0);
        if (w_rem >= (MagW + 1)'(CMD_MAX)) begin
            w_q = w_q0 + POS_W'(1);
        end else begin
            w_q = w_q0;
        end
        w_offset = SpanNeg ? POS_W'(~w_q + POS_W'(1)) : w_q;
        w_pos    = POS_W'(SERVO_MIN_POS) + w_offset;
    end

    assign o_res_ready = !r_valid || i_out_ready;
    assign w_load      = i_res_valid && o_res_ready;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_res;
            r_pos <= w_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_servo_position = r_pos;
    assign o_servo_command  = r_res.servo_command;
    assign o_mode           = r_res.mode;
    assign o_target_speed   = r_res.target_speed;
    assign o_low_speed      = r_res.low_speed;
    assign o_high_speed     = r_res.high_speed;
    assign o_autopilot      = r_res.autopilot;
    assign o_store_write    = r_res.store_write;

endmodule

@@ hw/rtl/cruise_speed_pid_controller.sv @@
// Top level of the cruise speed PID controller.
// Instantiates csp_front, csp_exec and csp_out; depends on csp_pkg.
//
// Usage:
//   Events enter on the input channel (i_in_valid / o_in_ready) as a kind
//   code and an 11-bit value: throttle, speed sample, second tick, next mode,
//   enter setup, leave setup. Each transaction yields exactly one result
//   transaction on the output channel (o_out_valid / i_out_ready) that shows
//   the servo position and command, mode, speeds, autopilot and store flag
//   after the event.
//   Throughput is one event per cycle while the receiver accepts results. A
//   result passes through the two-entry event queue, the execute stage with
//   its combinational PID update, and the output register.
//   When the receiver stalls, the output register, the execute result
//   register and the queue fill in turn; o_in_ready falls once the queue is
//   full and nothing is lost.
//   Configuration registers are written through i_cfg_we / i_cfg_addr /
//   i_cfg_data; the user must do so while no event is in flight, unchecked by the block.
//   Synchronous reset (i_rst_n low) empties the pipeline, puts the controller
//   in off mode with all speeds, command and integral at zero, and restores
//   the default gains and periods.
module cruise_speed_pid_controller
    import csp_pkg::*;
#(
    parameter int SPEED_BITS    = DEF_SPEED_BITS,
    parameter int SERVO_MAX_POS = DEF_SERVO_MAX_POS,
    parameter int SERVO_MIN_POS = DEF_SERVO_MIN_POS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [VALUE_W-1:0]     i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [POS_W-1:0]       o_servo_position,
    output logic [CMD_W-1:0]       o_servo_command,
    output logic [MODE_OUT_W-1:0]  o_mode,
    output logic [SPEED_OUT_W-1:0] o_target_speed,
    output logic [SPEED_OUT_W-1:0] o_low_speed,
    output logic [SPEED_OUT_W-1:0] o_high_speed,
    output logic                   o_autopilot,
    output logic                   o_store_write
);

    t_cmd    w_head;
    logic    w_head_valid;
    logic    w_pop;
    t_result w_res;
    logic    w_res_valid;
    logic    w_res_ready;

    // Event acceptance, classification and queue.
    csp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    // Controller state, configuration and PID update.
    csp_exec #(
        .SPEED_BITS (SPEED_BITS)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_head),
        .i_cmd_valid (w_head_valid),
        .o_pop       (w_pop),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready)
    );

    // Servo position mapping and output register.
    csp_out #(
        .SERVO_MAX_POS (SERVO_MAX_POS),
        .SERVO_MIN_POS (SERVO_MIN_POS)
    ) u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_res            (w_res),
        .i_res_valid      (w_res_valid),
        .o_res_ready      (w_res_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_servo_position (o_servo_position),
        .o_servo_command  (o_servo_command),
        .o_mode           (o_mode),
        .o_target_speed   (o_target_speed),
        .o_low_speed      (o_low_speed),
        .o_high_speed     (o_high_speed),
        .o_autopilot      (o_autopilot),
        .o_store_write    (o_store_write)
    );

endmodule

@@ dv/tb_cruise_speed_pid_controller.sv @@
// Self-checking testbench for the cruise speed PID controller.
// Drives events over the input channel and checks every result against a cycle-free
// model of the controller held here; depends on csp_pkg and cruise_speed_pid_controller.
module tb_cruise_speed_pid_controller;
    import csp_pkg::*;

    // One pending input event.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } t_event_item;

    // One expected result: the servo position and the remaining fields.
    typedef struct packed {
        logic [POS_W-1:0] position;
        t_result          fields;
    } t_ctrl_result;

    localparam int INTEG_MAX = 32767;
    localparam int INTEG_MIN = -32768;
    localparam int SPEED_TOP = 2047;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [KIND_W-1:0]      i_kind = '0;
    logic [VALUE_W-1:0]     i_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [POS_W-1:0]       o_servo_position;
    logic [CMD_W-1:0]       o_servo_command;
    logic [MODE_OUT_W-1:0]  o_mode;
    logic [SPEED_OUT_W-1:0] o_target_speed;
    logic [SPEED_OUT_W-1:0] o_low_speed;
    logic [SPEED_OUT_W-1:0] o_high_speed;
    logic                   o_autopilot;
    logic                   o_store_write;

    cruise_speed_pid_controller DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_servo_position(o_servo_position),
        .o_servo_command (o_servo_command),
        .o_mode          (o_mode),
        .o_target_speed  (o_target_speed),
        .o_low_speed     (o_low_speed),
        .o_high_speed    (o_high_speed),
        .o_autopilot     (o_autopilot),
        .o_store_write   (o_store_write)
    );

    // Clock with a period of 12 units.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Controller state as predicted, starting from its reset values.
    t_mode                  mode_q = MODE_OFF;
    bit                     in_setup = 1'b0;
    logic [SPEED_OUT_W-1:0] low_spd = '0;
    logic [SPEED_OUT_W-1:0] high_spd = '0;
    logic [SPEED_OUT_W-1:0] target_spd = '0;
    logic [SPEED_OUT_W-1:0] last_spd = '0;
    logic [CMD_W-1:0]       servo_cmd = '0;
    int                     integ = 0;
    int                     prev_err = 0;
    bit                     no_prev_err = 1'b1;
    int                     secs = 0;
    int                     prop_k = int'(RST_PROP_GAIN);
    int                     int_k = int'(RST_INT_GAIN);
    int                     deriv_k = int'(RST_DERIV_GAIN);
    int                     slow_per = int'(RST_SLOW_PERIOD);
    int                     fast_per = int'(RST_FAST_PERIOD);

    t_event_item  pending_events[$];
    t_ctrl_result awaited_results[$];
    int           items_queued = 0;
    int           mismatches = 0;
    bit           steady_in = 1'b0;
    bit           steady_out = 1'b0;
    int           in_gap = 0;
    int           out_hold = 0;
    int           stall_draw;
    t_event_item  next_item;
    t_ctrl_result want;

    function automatic bit cruising();
        return !in_setup && mode_q != MODE_OFF && target_spd != 0;
    endfunction

    function automatic logic [CMD_W-1:0] clamp_command(longint v);
        if (v < 0)
            return '0;
        if (v > CMD_MAX)
            return CMD_W'(CMD_MAX);
        return CMD_W'(v);
    endfunction

    // PID correction on the latest speed sample; updates integral and previous error.
    function automatic longint pid_correction();
        int     err;
        int     diff;
        longint acc;
        err = int'(target_spd) - int'(last_spd);
        // With no earlier error the derivative term starts at zero.
        if (no_prev_err) begin
            prev_err = err;
            no_prev_err = 1'b0;
        end
        acc = longint'(integ) + err;
        if (acc > INTEG_MAX)
            acc = INTEG_MAX;
        else if (acc < INTEG_MIN)
            acc = INTEG_MIN;
        integ = int'(acc);
        diff = err - prev_err;
        prev_err = err;
        return longint'(err) * prop_k + longint'(integ) * int_k + longint'(diff) * deriv_k;
    endfunction

    // One-second tick: the counter runs only in slow or fast cruise and swaps the target.
    function automatic void second_tick();
        int n;
        n = secs + 1;
        if (!cruising() || mode_q == MODE_STATIC) begin
            secs = 0;
        end else if ((mode_q == MODE_SLOW && n > slow_per) ||
                     (mode_q == MODE_FAST && n > fast_per)) begin
            target_spd = (target_spd == low_spd) ? high_spd : low_spd;
            secs = 0;
        end else begin
            secs = (n > 255) ? 255 : n;
        end
    endfunction

    // Applies one event to the predicted state and returns the result it gives.
    function automatic t_ctrl_result controller_step(logic [KIND_W-1:0] kind,
                                                     logic [VALUE_W-1:0] value);
        t_ctrl_result r;
        bit           saved;
        saved = 1'b0;
        case (kind)
            KIND_THROTTLE: begin
                mode_q = MODE_OFF;
                servo_cmd = clamp_command(longint'(value));
            end
            KIND_SPEED: begin
                last_spd = value;
                if (cruising())
                    servo_cmd = clamp_command(longint'(servo_cmd) + pid_correction());
            end
            KIND_TICK: begin
                second_tick();
            end
            KIND_NEXT_MODE: begin
                case (mode_q)
                    MODE_OFF: begin
                        mode_q = MODE_STATIC;
                        target_spd = low_spd;
                    end
                    MODE_STATIC: mode_q = MODE_SLOW;
                    MODE_SLOW:   mode_q = MODE_FAST;
                    default:     mode_q = MODE_STATIC;
                endcase
            end
            KIND_SETUP_ENTER: begin
                in_setup = 1'b1;
                low_spd = last_spd;
            end
            KIND_SETUP_LEAVE: begin
                in_setup = 1'b0;
                if (last_spd < low_spd) begin
                    high_spd = low_spd;
                    low_spd = last_spd;
                end else begin
                    high_spd = last_spd;
                end
                saved = 1'b1;
            end
            default: begin
            end
        endcase
        r.position = POS_W'(int'(servo_cmd) * (DEF_SERVO_MAX_POS - DEF_SERVO_MIN_POS) / CMD_MAX
                            + DEF_SERVO_MIN_POS);
        r.fields.servo_command = servo_cmd;
        r.fields.mode = in_setup ? MODE_CODE_SETUP : MODE_OUT_W'(mode_q);
        r.fields.target_speed = target_spd;
        r.fields.low_speed = low_spd;
        r.fields.high_speed = high_spd;
        r.fields.autopilot = cruising();
        r.fields.store_write = saved;
        return r;
    endfunction

    function automatic void queue_event(logic [KIND_W-1:0] kind, int value);
        pending_events.push_back('{kind, value[VALUE_W-1:0]});
        // Undefined kind codes leave the controller untouched and are not counted.
        if (kind <= KIND_SETUP_LEAVE)
            items_queued++;
    endfunction

    // A speed sample a little either side of the present target.
    function automatic int near_target();
        int v;
        v = int'(target_spd) + $urandom_range(0, 32) - 16;
        if (v < 0)
            v = 0;
        if (v > SPEED_TOP)
            v = SPEED_TOP;
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    // Input driver: presents queued events, with a random gap after each one unless steady_in is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid)
                awaited_results.push_back(controller_step(i_kind, i_value));
            if (in_gap != 0) begin
                i_in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_events.size() != 0) begin
                next_item = pending_events.pop_front();
                i_in_valid <= 1'b1;
                i_kind <= next_item.kind;
                i_value <= next_item.value;
                in_gap <= steady_in ? 0 : $urandom_range(0, 3);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each result transaction and stalls the receiver at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited, servo_command",
                                32'(o_servo_command), 32'd0);
            end else begin
                want = awaited_results.pop_front();
                if (o_servo_position !== want.position)
                    report_mismatch("servo_position", 32'(o_servo_position),
                                    32'(want.position));
                if (o_servo_command !== want.fields.servo_command)
                    report_mismatch("servo_command", 32'(o_servo_command),
                                    32'(want.fields.servo_command));
                if (o_mode !== want.fields.mode)
                    report_mismatch("mode", 32'(o_mode), 32'(want.fields.mode));
                if (o_target_speed !== want.fields.target_speed)
                    report_mismatch("target_speed", 32'(o_target_speed),
                                    32'(want.fields.target_speed));
                if (o_low_speed !== want.fields.low_speed)
                    report_mismatch("low_speed", 32'(o_low_speed),
                                    32'(want.fields.low_speed));
                if (o_high_speed !== want.fields.high_speed)
                    report_mismatch("high_speed", 32'(o_high_speed),
                                    32'(want.fields.high_speed));
                if (o_autopilot !== want.fields.autopilot)
                    report_mismatch("autopilot", 32'(o_autopilot),
                                    32'(want.fields.autopilot));
                if (o_store_write !== want.fields.store_write)
                    report_mismatch("store_write", 32'(o_store_write),
                                    32'(want.fields.store_write));
            end
            stall_draw = steady_out ? 0 : $urandom_range(0, 3);
            out_hold <= stall_draw;
            i_out_ready <= (stall_draw == 0);
        end else if (out_hold > 1) begin
            out_hold <= out_hold - 1;
        end else begin
            out_hold <= 0;
            i_out_ready <= 1'b1;
        end
    end

    // Writes one register and mirrors it in the predicted state.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        case (idx)
            CFG_LOW_INITIAL:  low_spd = SPEED_OUT_W'(data);
            CFG_HIGH_INITIAL: high_spd = SPEED_OUT_W'(data);
            CFG_PROP_GAIN:    prop_k = int'(data[GAIN_W-1:0]);
            CFG_INT_GAIN:     int_k = int'(data[GAIN_W-1:0]);
            CFG_DERIV_GAIN:   deriv_k = int'(data[GAIN_W-1:0]);
            CFG_SLOW_PERIOD:  slow_per = int'(data[GAIN_W-1:0]);
            CFG_FAST_PERIOD:  fast_per = int'(data[GAIN_W-1:0]);
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(int lo, int hi, int kp, int ki, int kd, int sp, int fp);
        write_reg(CFG_LOW_INITIAL, lo);
        write_reg(CFG_HIGH_INITIAL, hi);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INT_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_SLOW_PERIOD, sp);
        write_reg(CFG_FAST_PERIOD, fp);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every event has been accepted and every result checked,
    // then lets the pipeline settle before the registers change.
    task automatic drain();
        while (pending_events.size() != 0 || i_in_valid || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Queues one short, mostly well-formed sequence of events.
    task automatic add_scenario();
        int pick;
        int sel;
        int rail;
        while (pending_events.size() > 2)
            @(negedge i_clk);
        steady_in = ($urandom_range(0, 3) == 0);
        steady_out = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // Cruise run: speed samples around the target mixed with ticks.
            if (mode_q == MODE_OFF || $urandom_range(0, 1) == 1)
                queue_event(KIND_NEXT_MODE, $urandom_range(0, SPEED_TOP));
            repeat ($urandom_range(5, 20)) begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    queue_event(KIND_SPEED, near_target());
                else if (sel < 9)
                    queue_event(KIND_TICK, $urandom_range(0, SPEED_TOP));
                else
                    queue_event(KIND_NEXT_MODE, $urandom_range(0, SPEED_TOP));
            end
        end else if (pick < 50) begin
            // Setup: learn the low and high speeds from samples.
            queue_event(KIND_SPEED, $urandom_range(0, SPEED_TOP));
            queue_event(KIND_SETUP_ENTER, $urandom_range(0, SPEED_TOP));
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 4) == 0)
                    queue_event(KIND_NEXT_MODE, $urandom_range(0, SPEED_TOP));
                else
                    queue_event(KIND_SPEED, $urandom_range(0, SPEED_TOP));
            end
            queue_event(KIND_SETUP_LEAVE, $urandom_range(0, SPEED_TOP));
            if ($urandom_range(0, 1) == 1)
                queue_event(KIND_NEXT_MODE, $urandom_range(0, SPEED_TOP));
        end else if (pick < 60) begin
            // Manual throttle, then back towards cruise.
            queue_event(KIND_THROTTLE, $urandom_range(0, SPEED_TOP));
            if ($urandom_range(0, 1) == 1)
                queue_event(KIND_NEXT_MODE, $urandom_range(0, SPEED_TOP));
        end else if (pick < 75) begin
            // A run of ticks to reach the swap periods.
            repeat ($urandom_range(3, 12)) begin
                if ($urandom_range(0, 3) == 0)
                    queue_event(KIND_SPEED, near_target());
                else
                    queue_event(KIND_TICK, $urandom_range(0, SPEED_TOP));
            end
        end else if (pick < 90) begin
            // Noise: any kind code, any value.
            repeat ($urandom_range(1, 4))
                queue_event(KIND_W'($urandom_range(0, 7)), $urandom_range(0, SPEED_TOP));
        end else begin
            // Speeds pinned at one extreme to drive the integral into saturation.
            if (mode_q == MODE_OFF)
                queue_event(KIND_NEXT_MODE, 0);
            rail = ($urandom_range(0, 1) == 1) ? SPEED_TOP : 0;
            repeat ($urandom_range(15, 30))
                queue_event(KIND_SPEED, rail);
        end
    endtask

    task automatic run_random(int count);
        items_queued = 0;
        while (items_queued < count)
            add_scenario();
        drain();
    endtask

    // Main sequence: reset, directed events, then random phases under several settings.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short periods so the swaps, and a zero fast period, show up at once.
        apply_settings(300, 600, 10, 5, 2, 2, 0);
        @(negedge i_clk);
        queue_event(3'd6, SPEED_TOP);
        queue_event(3'd7, 0);
        queue_event(KIND_THROTTLE, SPEED_TOP);
        queue_event(KIND_THROTTLE, CMD_MAX);
        queue_event(KIND_THROTTLE, 0);
        queue_event(KIND_SPEED, SPEED_TOP);
        queue_event(KIND_TICK, 0);
        queue_event(KIND_NEXT_MODE, 0);
        queue_event(KIND_SPEED, 250);
        queue_event(KIND_SPEED, 320);
        queue_event(KIND_NEXT_MODE, 0);
        queue_event(KIND_TICK, 0);
        queue_event(KIND_TICK, 0);
        queue_event(KIND_TICK, 0);
        queue_event(KIND_NEXT_MODE, 0);
        queue_event(KIND_TICK, 0);
        queue_event(KIND_NEXT_MODE, 0);
        queue_event(KIND_SETUP_ENTER, 0);
        queue_event(KIND_NEXT_MODE, 0);
        queue_event(KIND_SPEED, 100);
        queue_event(KIND_SETUP_LEAVE, 0);
        queue_event(KIND_SPEED, 900);
        queue_event(KIND_SETUP_LEAVE, 0);
        queue_event(KIND_SETUP_ENTER, 0);
        queue_event(KIND_THROTTLE, 500);
        queue_event(KIND_SETUP_LEAVE, 0);
        drain();

        // Default gains with random speeds and short periods.
        apply_settings($urandom_range(100, 1500), $urandom_range(0, SPEED_TOP), 10, 5, 2,
                       $urandom_range(2, 6), 1);
        run_random(170);

        // Largest gains, largest low speed with zero high speed, longest slow period.
        apply_settings(SPEED_TOP, 0, 255, 255, 255, 255, 1);
        run_random(170);

        // Zero gains, zero low speed, shortest slow period.
        apply_settings(0, SPEED_TOP, 0, 0, 0, 1, 255);
        run_random(170);

        // Small random gains keep the command away from its limits.
        apply_settings($urandom_range(0, SPEED_TOP), $urandom_range(0, SPEED_TOP),
                       $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                       $urandom_range(1, 12), $urandom_range(1, 12));
        run_random(170);

        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb_cruise_speed_pid_controller passed");
        else
            $display("tb_cruise_speed_pid_controller failed");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2400000;
        $display("tb_cruise_speed_pid_controller failed");
        $finish;
    end

endmodule

@@ cruise_speed_pid_controller.f @@
hw/rtl/csp_pkg.sv
hw/rtl/csp_front.sv
hw/rtl/csp_exec.sv
hw/rtl/csp_out.sv
hw/rtl/cruise_speed_pid_controller.sv
dv/tb_cruise_speed_pid_controller.sv
